@@ hw/rtl/gdrc_pkg.sv @@
// shared types, constants and the sine table builder of the column raycaster
package gdrc_pkg;

   localparam int DIVIDEND_W = 27;
   localparam int DIVISOR_W  = 20;
   localparam int DIV_CNT_W  = 5;
   localparam int CELL_W     = 8;
   localparam int SIDE_W     = 54;
   localparam int DELTA_W    = 41;
   localparam int PROD_W     = 25;

   localparam logic CMD_MAP_WRITE = 1'b0;
   localparam logic CMD_CAST      = 1'b1;

   localparam logic [1:0] CSR_PLAYER_X     = 2'd0;
   localparam logic [1:0] CSR_PLAYER_Y     = 2'd1;
   localparam logic [1:0] CSR_PLAYER_ANGLE = 2'd2;
   localparam logic [1:0] CSR_VIEW_SPAN    = 2'd3;

   localparam logic [15:0] RESET_PLAYER_X     = 16'd6144;
   localparam logic [15:0] RESET_PLAYER_Y     = 16'd6144;
   localparam logic [15:0] RESET_PLAYER_ANGLE = 16'd0;
   localparam logic [14:0] RESET_VIEW_SPAN    = 15'd10923;

   localparam logic [19:0] MIN_DIST  = 20'd41;
   localparam logic [19:0] MAX_DIST  = 20'hFFFFF;
   localparam logic [20:0] SHADE_CAP = 21'd55706;
   localparam logic [16:0] SHADE_ONE = 17'd65536;
   localparam logic [DIVIDEND_W-1:0] RECIP_ONE = 27'h400_0000;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic        is_cast;
      logic [3:0]  row_index;
      logic [15:0] row_walls;
      logic [PROD_W-1:0] col_prod;
   } entry_type;

   typedef struct packed {
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_status_type;

   // wall base colour per side and channel
   function automatic logic [7:0] base_colour(input logic side, input logic [1:0] ch);
      logic [7:0] c;
      c = 8'h00;
      case ({side, ch})
         {1'b0, CH_RED}:   c = 8'h55;
         {1'b0, CH_GREEN}: c = 8'h88;
         {1'b0, CH_BLUE}:  c = 8'hAA;
         {1'b1, CH_RED}:   c = 8'h33;
         {1'b1, CH_GREEN}: c = 8'h55;
         {1'b1, CH_BLUE}:  c = 8'h77;
         default:          c = 8'h00;
      endcase
      return c;
   endfunction

   // sine in signed q1.14 from a 16-bit phase, taylor series on the folded quarter wave
   function automatic logic signed [15:0] sine_from_phase(input longint unsigned phase);
      longint unsigned quad;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned v;
      logic signed [15:0] v16;
      quad = (phase >> 14) & 64'd3;
      r = phase & 64'h3FFF;
      if (quad[0]) r = 64'd16384 - r;
      x = r * 64'd102944;
      x2 = (x * x) >> 30;
      t = (64'd1 << 30) - x2 / 64'd110;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
      v = (((x * t) >> 30) + 64'd32768) >> 16;
      if (v > 64'd16384) v = 64'd16384;
      v16 = v[15:0];
      return (quad >= 64'd2) ? -v16 : v16;
   endfunction

endpackage

@@ hw/rtl/gdrc_front.sv @@
// front end: takes request transfers, classifies them and forms the queue entry
module gdrc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [9:0]          req_column,
   input  logic [3:0]          req_row_index,
   input  logic [15:0]         req_row_walls,
   input  logic [14:0]         view_span,
   input  logic                q_full,
   output logic                q_push,
   output gdrc_pkg::entry_type q_entry
);

   logic                slot_valid_ff, slot_valid_in;
   gdrc_pkg::entry_type slot_ff, slot_in;
   logic                accept;

   assign q_push    = slot_valid_ff && !q_full;
   assign req_ready = !slot_valid_ff || !q_full;
   assign accept    = req_valid && req_ready;
   assign q_entry   = slot_ff;

   always_comb begin
      slot_valid_in = slot_valid_ff;
      slot_in       = slot_ff;
      if (q_push) slot_valid_in = 1'b0;
      if (accept) begin
         slot_valid_in     = 1'b1;
         slot_in.is_cast   = (req_command == gdrc_pkg::CMD_CAST);
         slot_in.row_index = req_row_index;
         slot_in.row_walls = req_row_walls;
         // column times field of view, scaled to an angle offset later
         slot_in.col_prod  = gdrc_pkg::PROD_W'(req_column) * gdrc_pkg::PROD_W'(view_span);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) slot_valid_ff <= 1'b0;
      else       slot_valid_ff <= slot_valid_in;
      slot_ff <= slot_in;
   end

endmodule

@@ hw/rtl/gdrc_queue.sv @@
// two-entry queue between the front end and the marching engine
module gdrc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gdrc_pkg::entry_type push_entry,
   input  logic                pop,
   output gdrc_pkg::entry_type head,
   output logic                full,
   output logic                empty
);

   gdrc_pkg::entry_type entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) entries_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

@@ hw/rtl/gdrc_div.sv @@
// restoring divider, one quotient bit per cycle
module gdrc_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  gdrc_pkg::div_req_type    req,
   output gdrc_pkg::div_status_type status
);

   localparam int DW = gdrc_pkg::DIVIDEND_W;
   localparam int VW = gdrc_pkg::DIVISOR_W;

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [gdrc_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DW-1:0]                    num_ff, num_in;
   logic [DW-1:0]                    quot_ff, quot_in;
   logic [VW-1:0]                    rem_ff, rem_in;
   logic [VW-1:0]                    den_ff, den_in;
   logic [VW:0]                      rem_shift;
   logic                             fits;

   assign rem_shift = {rem_ff, num_ff[DW-1]};
   assign fits      = (rem_shift >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = gdrc_pkg::DIV_CNT_W'(DW - 1);
         num_in  = req.dividend;
         den_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? VW'(rem_shift - {1'b0, den_ff}) : rem_shift[VW-1:0];
         quot_in = {quot_ff[DW-2:0], fits};
         num_in  = {num_ff[DW-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign status.busy     = busy_ff;
   assign status.done     = done_ff;
   assign status.quotient = quot_ff;

endmodule

@@ hw/rtl/gdrc_march.sv @@
// back end: map store, angle and trig setup, grid march, span and shading
module gdrc_march #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 400,
   parameter int MAP_SIDE      = 16,
   parameter int SINE_ENTRIES  = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   output logic                q_pop,
   input  gdrc_pkg::entry_type q_head,
   input  logic [15:0]         player_x,
   input  logic [15:0]         player_y,
   input  logic [15:0]         player_angle,
   input  logic [14:0]         view_span,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [8:0]          rsp_span_top,
   output logic [8:0]          rsp_span_bottom,
   output logic                rsp_hit_side,
   output logic                rsp_wall_found,
   output logic signed [5:0]   rsp_cell_x,
   output logic signed [5:0]   rsp_cell_y,
   output logic [19:0]         rsp_distance,
   output logic [7:0]          rsp_wall_red,
   output logic [7:0]          rsp_wall_green,
   output logic [7:0]          rsp_wall_blue
);

   localparam int MAP_ROWS = (MAP_SIDE < 16) ? MAP_SIDE : 16;
   localparam int CELL_MAX = (MAP_SIDE > 16) ? MAP_SIDE : 16;
   localparam int IDX_W    = $clog2(SINE_ENTRIES);
   localparam int CW       = gdrc_pkg::CELL_W;
   localparam int SW       = gdrc_pkg::SIDE_W;
   localparam int DLW      = gdrc_pkg::DELTA_W;
   localparam int DW       = gdrc_pkg::DIVIDEND_W;

   // column offset by reciprocal multiplication, exact for every column product
   localparam int WIDTH_LOG = $clog2(SCREEN_WIDTH);
   localparam int COL_SHIFT = gdrc_pkg::PROD_W + WIDTH_LOG;
   localparam longint unsigned COL_RECIP =
      ((64'd1 << COL_SHIFT) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_TRIG    = 4'd2;
   localparam logic [3:0] S_DELTA_X = 4'd3;
   localparam logic [3:0] S_DELTA_Y = 4'd4;
   localparam logic [3:0] S_SETUP   = 4'd5;
   localparam logic [3:0] S_MARCH   = 4'd6;
   localparam logic [3:0] S_DIST    = 4'd7;
   localparam logic [3:0] S_HEIGHT  = 4'd8;
   localparam logic [3:0] S_EMIT    = 4'd9;

   // sine table, built at elaboration
   logic signed [15:0] sine_rom [SINE_ENTRIES];
   for (genvar i = 0; i < SINE_ENTRIES; i++) begin : g_sine
      localparam longint unsigned PHASE = (longint'(i) * 65536) / SINE_ENTRIES;
      assign sine_rom[i] = gdrc_pkg::sine_from_phase(PHASE);
   end

   logic [3:0]             state_ff, state_in;
   logic [15:0]            map_ff [MAP_ROWS];
   logic [15:0]            map_in [MAP_ROWS];
   logic [15:0]            angle_ff, angle_in;
   logic                   neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [14:0]            mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic [DLW-1:0]         delta_x_ff, delta_x_in, delta_y_ff, delta_y_in;
   logic [SW-1:0]          side_x_ff, side_x_in, side_y_ff, side_y_in;
   logic signed [CW-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic                   hit_y_ff, hit_y_in;
   logic                   found_ff, found_in;
   logic                   moved_ff, moved_in;
   logic [19:0]            dist_ff, dist_in;

   logic                   out_valid_ff, out_valid_in;
   logic [8:0]             out_top_ff, out_top_in, out_bot_ff, out_bot_in;
   logic                   out_side_ff, out_side_in, out_found_ff, out_found_in;
   logic signed [5:0]      out_cx_ff, out_cx_in, out_cy_ff, out_cy_in;
   logic [19:0]            out_dist_ff, out_dist_in;
   logic [7:0]             out_r_ff, out_r_in, out_g_ff, out_g_in, out_b_ff, out_b_in;

   logic                     div_start;
   gdrc_pkg::div_req_type    div_req;
   gdrc_pkg::div_status_type div_status;

   gdrc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .req    (div_req),
      .status (div_status)
   );

   // column product scaled down to an angle offset
   logic [51:0] col_scaled;
   logic [15:0] col_offset;
   assign col_scaled = 52'(q_head.col_prod) * 52'(COL_RECIP);
   assign col_offset = 16'(col_scaled >> COL_SHIFT);

   // trig lookup
   logic [15:0]        cos_angle;
   logic [IDX_W-1:0]   sin_idx, cos_idx;
   logic signed [15:0] dir_x, dir_y;
   logic [15:0]        abs_x, abs_y;
   assign cos_angle = angle_ff + 16'd16384;
   assign sin_idx = IDX_W'((32'(angle_ff) * 32'(SINE_ENTRIES)) >> 16);
   assign cos_idx = IDX_W'((32'(cos_angle) * 32'(SINE_ENTRIES)) >> 16);
   assign dir_x = sine_rom[cos_idx];
   assign dir_y = sine_rom[sin_idx];
   assign abs_x = dir_x[15] ? 16'(-dir_x) : 16'(dir_x);
   assign abs_y = dir_y[15] ? 16'(-dir_y) : 16'(dir_y);

   // start distances
   logic [12:0]    frac_x, frac_y;
   logic [39:0]    prod_x, prod_y;
   assign frac_x = neg_x_ff ? {1'b0, player_x[11:0]} : 13'd4096 - {1'b0, player_x[11:0]};
   assign frac_y = neg_y_ff ? {1'b0, player_y[11:0]} : 13'd4096 - {1'b0, player_y[11:0]};
   assign prod_x = 40'(frac_x) * 40'(delta_x_ff[26:0]);
   assign prod_y = 40'(frac_y) * 40'(delta_y_ff[26:0]);

   // current cell test
   logic        out_of_map;
   logic [15:0] cur_row;
   logic        cur_wall;
   always_comb begin
      cur_row  = '0;
      cur_wall = 1'b0;
      for (int r = 0; r < MAP_ROWS; r++) begin
         if (cy_ff == r) cur_row = map_ff[r];
      end
      for (int c = 0; c < 16; c++) begin
         if (cx_ff == c) cur_wall = cur_row[c];
      end
   end
   assign out_of_map = (cx_ff < 0) || (cx_ff >= MAP_SIDE) || (cy_ff < 0) || (cy_ff >= MAP_SIDE);

   // distance and clamp
   logic [SW-1:0] raw_dist;
   logic [19:0]   clamp_dist;
   assign raw_dist = hit_y_ff ? side_y_ff - SW'(delta_y_ff) : side_x_ff - SW'(delta_x_ff);
   assign clamp_dist = (raw_dist < SW'(gdrc_pkg::MIN_DIST)) ? gdrc_pkg::MIN_DIST :
                       (raw_dist > SW'(gdrc_pkg::MAX_DIST)) ? gdrc_pkg::MAX_DIST :
                       raw_dist[19:0];

   // span and shade
   logic [DW:0]   wall_h, height_c, half_top, half_bot;
   logic [20:0]   shade_d;
   logic [16:0]   shade;
   logic [24:0]   mul_r, mul_g, mul_b;
   assign wall_h   = {1'b0, div_status.quotient};
   assign height_c = (DW + 1)'(SCREEN_HEIGHT);
   assign half_top = (wall_h <= height_c) ? (height_c - wall_h) >> 1 : '0;
   assign half_bot = ((height_c + wall_h) >> 1 > height_c) ? height_c : (height_c + wall_h) >> 1;
   assign shade_d  = {dist_ff, 1'b0};
   assign shade    = gdrc_pkg::SHADE_ONE -
                     17'((shade_d < gdrc_pkg::SHADE_CAP) ? shade_d : gdrc_pkg::SHADE_CAP);
   assign mul_r = 25'(gdrc_pkg::base_colour(hit_y_ff, gdrc_pkg::CH_RED)) * 25'(shade);
   assign mul_g = 25'(gdrc_pkg::base_colour(hit_y_ff, gdrc_pkg::CH_GREEN)) * 25'(shade);
   assign mul_b = 25'(gdrc_pkg::base_colour(hit_y_ff, gdrc_pkg::CH_BLUE)) * 25'(shade);

   logic out_free;
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      map_in     = map_ff;
      angle_in   = angle_ff;
      neg_x_in   = neg_x_ff;
      neg_y_in   = neg_y_ff;
      mag_x_in   = mag_x_ff;
      mag_y_in   = mag_y_ff;
      delta_x_in = delta_x_ff;
      delta_y_in = delta_y_ff;
      side_x_in  = side_x_ff;
      side_y_in  = side_y_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      hit_y_in   = hit_y_ff;
      found_in   = found_ff;
      moved_in   = moved_ff;
      dist_in    = dist_ff;
      q_pop      = 1'b0;
      div_start  = 1'b0;
      div_req.dividend = gdrc_pkg::RECIP_ONE;
      div_req.divisor  = '0;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_top_in   = out_top_ff;
      out_bot_in   = out_bot_ff;
      out_side_in  = out_side_ff;
      out_found_in = out_found_ff;
      out_cx_in    = out_cx_ff;
      out_cy_in    = out_cy_ff;
      out_dist_in  = out_dist_ff;
      out_r_in     = out_r_ff;
      out_g_in     = out_g_ff;
      out_b_in     = out_b_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_head.is_cast) begin
                  angle_in = player_angle - {1'b0, view_span[14:1]} + col_offset;
                  state_in = S_TRIG;
               end else begin
                  for (int r = 0; r < MAP_ROWS; r++) begin
                     if (q_head.row_index == 4'(r)) map_in[r] = q_head.row_walls;
                  end
               end
            end
         end
         S_TRIG: begin
            neg_x_in         = dir_x[15];
            neg_y_in         = dir_y[15];
            mag_x_in         = abs_x[14:0];
            mag_y_in         = abs_y[14:0];
            div_start        = 1'b1;
            div_req.divisor  = gdrc_pkg::DIVISOR_W'(abs_x[14:0]);
            state_in         = S_DELTA_X;
         end
         S_DELTA_X: begin
            if (div_status.done) begin
               delta_x_in = (mag_x_ff == '0) ? DLW'(1) << 40 : DLW'(div_status.quotient);
               div_start       = 1'b1;
               div_req.divisor = gdrc_pkg::DIVISOR_W'(mag_y_ff);
               state_in        = S_DELTA_Y;
            end
         end
         S_DELTA_Y: begin
            if (div_status.done) begin
               delta_y_in = (mag_y_ff == '0) ? DLW'(1) << 40 : DLW'(div_status.quotient);
               state_in   = S_SETUP;
            end
         end
         S_SETUP: begin
            side_x_in = (mag_x_ff == '0) ? {1'b0, frac_x, 40'b0} : SW'(prod_x);
            side_y_in = (mag_y_ff == '0) ? {1'b0, frac_y, 40'b0} : SW'(prod_y);
            cx_in     = $signed(CW'(player_x[15:12]));
            cy_in     = $signed(CW'(player_y[15:12]));
            moved_in  = 1'b0;
            state_in  = S_MARCH;
         end
         S_MARCH: begin
            if (moved_ff && (out_of_map || cur_wall)) begin
               found_in = !out_of_map;
               state_in = S_DIST;
            end else begin
               moved_in = 1'b1;
               if (side_x_ff < side_y_ff) begin
                  side_x_in = side_x_ff + SW'(delta_x_ff);
                  cx_in     = neg_x_ff ? cx_ff - CW'(1) : cx_ff + CW'(1);
                  hit_y_in  = 1'b0;
               end else begin
                  side_y_in = side_y_ff + SW'(delta_y_ff);
                  cy_in     = neg_y_ff ? cy_ff - CW'(1) : cy_ff + CW'(1);
                  hit_y_in  = 1'b1;
               end
            end
         end
         S_DIST: begin
            dist_in          = clamp_dist;
            div_start        = 1'b1;
            div_req.dividend = DW'(SCREEN_HEIGHT * 4096);
            div_req.divisor  = clamp_dist;
            state_in         = S_HEIGHT;
         end
         S_HEIGHT: begin
            if (div_status.done) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_top_in   = half_top[8:0];
               out_bot_in   = half_bot[8:0];
               out_side_in  = hit_y_ff;
               out_found_in = found_ff;
               out_cx_in    = cx_ff[5:0];
               out_cy_in    = cy_ff[5:0];
               out_dist_in  = dist_ff;
               out_r_in     = mul_r[23:16];
               out_g_in     = mul_g[23:16];
               out_b_in     = mul_b[23:16];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         for (int r = 0; r < MAP_ROWS; r++) map_ff[r] <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         map_ff       <= map_in;
      end
      angle_ff   <= angle_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      mag_x_ff   <= mag_x_in;
      mag_y_ff   <= mag_y_in;
      delta_x_ff <= delta_x_in;
      delta_y_ff <= delta_y_in;
      side_x_ff  <= side_x_in;
      side_y_ff  <= side_y_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      hit_y_ff   <= hit_y_in;
      found_ff   <= found_in;
      moved_ff   <= moved_in;
      dist_ff    <= dist_in;
      out_top_ff   <= out_top_in;
      out_bot_ff   <= out_bot_in;
      out_side_ff  <= out_side_in;
      out_found_ff <= out_found_in;
      out_cx_ff    <= out_cx_in;
      out_cy_ff    <= out_cy_in;
      out_dist_ff  <= out_dist_in;
      out_r_ff     <= out_r_in;
      out_g_ff     <= out_g_in;
      out_b_ff     <= out_b_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_span_top    = out_top_ff;
   assign rsp_span_bottom = out_bot_ff;
   assign rsp_hit_side    = out_side_ff;
   assign rsp_wall_found  = out_found_ff;
   assign rsp_cell_x      = out_cx_ff;
   assign rsp_cell_y      = out_cy_ff;
   assign rsp_distance    = out_dist_ff;
   assign rsp_wall_red    = out_r_ff;
   assign rsp_wall_green  = out_g_ff;
   assign rsp_wall_blue   = out_b_ff;

   a_div_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   a_cell_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MARCH |-> (cx_ff >= -1 && cx_ff <= CELL_MAX && cy_ff >= -1 && cy_ff <= CELL_MAX))
      else $error("march cell out of range");

   a_dist_floor: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_dist_ff >= gdrc_pkg::MIN_DIST)
      else $error("distance below floor");

endmodule

@@ hw/rtl/grid_dda_raycast_column.sv @@
// column raycaster top level: csr registers, front end, queue and marching engine
// a cast passes the front end slot, the queue, then the engine states trig, delta x, delta y,
// setup, march (stepping one grid cell at a time), dist, height and emit into the result register;
// map writes are applied at the queue head; three divisions of 27 quotient bits dominate a cast
// the marching engine takes one cast at a time, the next queue item only once back in idle
// reset: synchronous, active high; clears the wall map, queue and handshakes and
// loads the default player position, angle and field of view
module grid_dda_raycast_column #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 400,
   parameter int MAP_SIDE      = 16,
   parameter int SINE_ENTRIES  = 1024
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_command,
   input  logic [9:0]        req_column,
   input  logic [3:0]        req_row_index,
   input  logic [15:0]       req_row_walls,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [8:0]        rsp_span_top,
   output logic [8:0]        rsp_span_bottom,
   output logic              rsp_hit_side,
   output logic              rsp_wall_found,
   output logic signed [5:0] rsp_cell_x,
   output logic signed [5:0] rsp_cell_y,
   output logic [19:0]       rsp_distance,
   output logic [7:0]        rsp_wall_red,
   output logic [7:0]        rsp_wall_green,
   output logic [7:0]        rsp_wall_blue,
   // register write port
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);

   // player state registers
   logic [15:0] player_x_ff, player_x_in;
   logic [15:0] player_y_ff, player_y_in;
   logic [15:0] player_angle_ff, player_angle_in;
   logic [14:0] view_span_ff, view_span_in;

   always_comb begin
      player_x_in     = player_x_ff;
      player_y_in     = player_y_ff;
      player_angle_in = player_angle_ff;
      view_span_in    = view_span_ff;
      if (csr_write) begin
         case (csr_index)
            gdrc_pkg::CSR_PLAYER_X:     player_x_in     = csr_data;
            gdrc_pkg::CSR_PLAYER_Y:     player_y_in     = csr_data;
            gdrc_pkg::CSR_PLAYER_ANGLE: player_angle_in = csr_data;
            gdrc_pkg::CSR_VIEW_SPAN:    view_span_in    = csr_data[14:0];
            default:                    player_x_in     = player_x_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff     <= gdrc_pkg::RESET_PLAYER_X;
         player_y_ff     <= gdrc_pkg::RESET_PLAYER_Y;
         player_angle_ff <= gdrc_pkg::RESET_PLAYER_ANGLE;
         view_span_ff    <= gdrc_pkg::RESET_VIEW_SPAN;
      end else begin
         player_x_ff     <= player_x_in;
         player_y_ff     <= player_y_in;
         player_angle_ff <= player_angle_in;
         view_span_ff    <= view_span_in;
      end
   end

   // front end to queue
   logic                q_full, q_empty, q_push, q_pop;
   gdrc_pkg::entry_type q_entry, q_head;

   gdrc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_column    (req_column),
      .req_row_index (req_row_index),
      .req_row_walls (req_row_walls),
      .view_span     (view_span_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   // map writes travel the queue too, so they stay ordered against casts
   gdrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   // marching engine with its own result register, so the next item can start
   // while a finished result waits for its transfer
   gdrc_march #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .MAP_SIDE      (MAP_SIDE),
      .SINE_ENTRIES  (SINE_ENTRIES)
   ) u_march (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .q_head          (q_head),
      .player_x        (player_x_ff),
      .player_y        (player_y_ff),
      .player_angle    (player_angle_ff),
      .view_span       (view_span_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_span_top    (rsp_span_top),
      .rsp_span_bottom (rsp_span_bottom),
      .rsp_hit_side    (rsp_hit_side),
      .rsp_wall_found  (rsp_wall_found),
      .rsp_cell_x      (rsp_cell_x),
      .rsp_cell_y      (rsp_cell_y),
      .rsp_distance    (rsp_distance),
      .rsp_wall_red    (rsp_wall_red),
      .rsp_wall_green  (rsp_wall_green),
      .rsp_wall_blue   (rsp_wall_blue)
   );

endmodule

@@ test/grid_dda_raycast_column_checker.sv @@
// checker for the column raycaster: tracks registers and wall map, predicts and compares results
`timescale 1ns / 100ps

module grid_dda_raycast_column_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_command,
   input  logic [9:0]        req_column,
   input  logic [3:0]        req_row_index,
   input  logic [15:0]       req_row_walls,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [8:0]        rsp_span_top,
   input  logic [8:0]        rsp_span_bottom,
   input  logic              rsp_hit_side,
   input  logic              rsp_wall_found,
   input  logic signed [5:0] rsp_cell_x,
   input  logic signed [5:0] rsp_cell_y,
   input  logic [19:0]       rsp_distance,
   input  logic [7:0]        rsp_wall_red,
   input  logic [7:0]        rsp_wall_green,
   input  logic [7:0]        rsp_wall_blue,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data,
   output int                fail_count,
   output int                column_backlog
);

   typedef struct packed {
      logic [8:0]  span_top;
      logic [8:0]  span_bottom;
      logic        hit_side;
      logic        wall_found;
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
      logic [19:0] distance;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } strip_type;

   logic [15:0] pos_x, pos_y, view_angle;
   logic [14:0] fov;
   logic [15:0] walls [16];
   strip_type   strips_due [$];

   // sine in q1.14 for a table slot, series evaluated on the folded quarter wave
   function automatic longint slot_sine(input int unsigned slot);
      longint unsigned ph, quad, r, x, x2, t, v;
      ph = (longint'(slot % 1024) << 16) / 1024;
      quad = (ph >> 14) & 3;
      r = ph & 16'h3FFF;
      if (quad[0]) r = 16384 - r;
      x = r * 102944;
      x2 = (x * x) >> 30;
      t = (64'd1 << 30) - x2 / 110;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      v = (((x * t) >> 30) + 32768) >> 16;
      if (v > 16384) v = 16384;
      return (quad >= 2) ? -longint'(v) : longint'(v);
   endfunction

   function automatic longint dir_of(input logic [15:0] ang);
      return slot_sine(int'(ang) >> 6);
   endfunction

   function automatic strip_type cast_column(input logic [9:0] col);
      logic [15:0] ang;
      longint dx, dy, sx, sy, cx, cy, wall_h, top, bot;
      longint unsigned dlx, dly, sdx, sdy, perp_dist, shade, mag;
      logic side, found;
      strip_type s;
      ang = 16'(view_angle - 16'(fov / 2) + 16'((longint'(col) * fov) / 640));
      dx = dir_of(ang + 16'd16384);
      dy = dir_of(ang);
      cx = pos_x >> 12;
      cy = pos_y >> 12;
      mag = (dx < 0) ? -dx : dx;
      dlx = (mag == 0) ? (64'd1 << 40) : (64'd1 << 26) / mag;
      sx  = (dx < 0) ? -1 : 1;
      sdx = (dx < 0) ? pos_x[11:0] * dlx : (4096 - pos_x[11:0]) * dlx;
      mag = (dy < 0) ? -dy : dy;
      dly = (mag == 0) ? (64'd1 << 40) : (64'd1 << 26) / mag;
      sy  = (dy < 0) ? -1 : 1;
      sdy = (dy < 0) ? pos_y[11:0] * dly : (4096 - pos_y[11:0]) * dly;
      side = 0;
      found = 0;
      forever begin
         if (sdx < sdy) begin
            sdx += dlx; cx += sx; side = 0;
         end else begin
            sdy += dly; cy += sy; side = 1;
         end
         if (cx < 0 || cx >= 16 || cy < 0 || cy >= 16) break;
         if (walls[cy][cx]) begin
            found = 1;
            break;
         end
      end
      perp_dist = side ? sdy - dly : sdx - dlx;
      if (perp_dist < 41) perp_dist = 41;
      if (perp_dist > 20'hFFFFF) perp_dist = 20'hFFFFF;
      wall_h = (400 * 4096) / perp_dist;
      top = (400 - wall_h) / 2;
      bot = (400 + wall_h) / 2;
      if (top < 0) top = 0;
      if (bot > 400) bot = 400;
      shade = 65536 - ((2 * perp_dist < 55706) ? 2 * perp_dist : 55706);
      s.span_top    = 9'(top);
      s.span_bottom = 9'(bot);
      s.hit_side    = side;
      s.wall_found  = found;
      s.cell_x      = 6'(cx);
      s.cell_y      = 6'(cy);
      s.distance    = 20'(perp_dist);
      // wall colour, darker on y boundaries and with distance
      s.red   = 8'(((side ? 64'h33 : 64'h55) * shade) >> 16);
      s.green = 8'(((side ? 64'h55 : 64'h88) * shade) >> 16);
      s.blue  = 8'(((side ? 64'h77 : 64'hAA) * shade) >> 16);
      return s;
   endfunction

   always @(posedge clock) begin
      strip_type want;
      if (reset) begin
         pos_x      = gdrc_pkg::RESET_PLAYER_X;
         pos_y      = gdrc_pkg::RESET_PLAYER_Y;
         view_angle = gdrc_pkg::RESET_PLAYER_ANGLE;
         fov        = gdrc_pkg::RESET_VIEW_SPAN;
         foreach (walls[i]) walls[i] = '0;
         strips_due.delete();
         fail_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               gdrc_pkg::CSR_PLAYER_X:     pos_x = csr_data;
               gdrc_pkg::CSR_PLAYER_Y:     pos_y = csr_data;
               gdrc_pkg::CSR_PLAYER_ANGLE: view_angle = csr_data;
               gdrc_pkg::CSR_VIEW_SPAN:    fov = csr_data[14:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_command == gdrc_pkg::CMD_CAST) strips_due.push_back(cast_column(req_column));
            else walls[req_row_index] = req_row_walls;
         end
         if (rsp_valid && rsp_ready) begin
            if (strips_due.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count++;
            end else begin
               want = strips_due.pop_front();
               if (rsp_span_top !== want.span_top) begin
                  $error("span_top expected %0d got %0d", want.span_top, rsp_span_top);
                  fail_count++;
               end
               if (rsp_span_bottom !== want.span_bottom) begin
                  $error("span_bottom expected %0d got %0d", want.span_bottom, rsp_span_bottom);
                  fail_count++;
               end
               if (rsp_hit_side !== want.hit_side) begin
                  $error("hit_side expected %0d got %0d", want.hit_side, rsp_hit_side);
                  fail_count++;
               end
               if (rsp_wall_found !== want.wall_found) begin
                  $error("wall_found expected %0d got %0d", want.wall_found, rsp_wall_found);
                  fail_count++;
               end
               if (rsp_cell_x !== want.cell_x) begin
                  $error("cell_x expected %0d got %0d", $signed(want.cell_x), rsp_cell_x);
                  fail_count++;
               end
               if (rsp_cell_y !== want.cell_y) begin
                  $error("cell_y expected %0d got %0d", $signed(want.cell_y), rsp_cell_y);
                  fail_count++;
               end
               if (rsp_distance !== want.distance) begin
                  $error("distance expected %0d got %0d", want.distance, rsp_distance);
                  fail_count++;
               end
               if (rsp_wall_red !== want.red) begin
                  $error("wall_red expected %0d got %0d", want.red, rsp_wall_red);
                  fail_count++;
               end
               if (rsp_wall_green !== want.green) begin
                  $error("wall_green expected %0d got %0d", want.green, rsp_wall_green);
                  fail_count++;
               end
               if (rsp_wall_blue !== want.blue) begin
                  $error("wall_blue expected %0d got %0d", want.blue, rsp_wall_blue);
                  fail_count++;
               end
            end
         end
      end
      column_backlog = strips_due.size();
   end

endmodule

@@ test/tb_grid_dda_raycast_column.sv @@
// testbench top of the column raycaster: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_grid_dda_raycast_column;

   logic              clock;
   logic              reset;
   logic              req_valid, req_ready, req_command;
   logic [9:0]        req_column;
   logic [3:0]        req_row_index;
   logic [15:0]       req_row_walls;
   logic              rsp_valid, rsp_ready;
   logic [8:0]        rsp_span_top, rsp_span_bottom;
   logic              rsp_hit_side, rsp_wall_found;
   logic signed [5:0] rsp_cell_x, rsp_cell_y;
   logic [19:0]       rsp_distance;
   logic [7:0]        rsp_wall_red, rsp_wall_green, rsp_wall_blue;
   logic              csr_write;
   logic [1:0]        csr_index;
   logic [15:0]       csr_data;
   int                fail_count, column_backlog;
   bit                calm;        // no gaps or stalls on either side
   int                stall_left;

   grid_dda_raycast_column dut (.*);
   grid_dda_raycast_column_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #40_000_000;
      $display("tb_grid_dda_raycast_column NOT OK");
      $finish;
   end

   // result side back-pressure: mostly ready, short stalls, now and then a long one
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < 15) begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(9) == 0) ? $urandom_range(80, 30) : $urandom_range(2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one request transfer; valid is left high afterwards so back-to-back items need no dip
   task automatic send_item(input logic cmd, input logic [9:0] col, input logic [3:0] row,
                            input logic [15:0] bits);
      int gap;
      gap = 0;
      if (!calm) gap = ($urandom_range(19) == 0) ? $urandom_range(60, 15)
                                                 : ($urandom_range(2) == 0 ? 0 : $urandom_range(3));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_column    <= col;
      req_row_index <= row;
      req_row_walls <= bits;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic cast(input logic [9:0] col);
      send_item(gdrc_pkg::CMD_CAST, col, 4'($urandom), 16'($urandom));
   endtask

   task automatic store_row(input logic [3:0] row, input logic [15:0] bits);
      send_item(gdrc_pkg::CMD_MAP_WRITE, 10'($urandom), row, bits);
   endtask

   // let every outstanding cast come back, then allow for a map write still in flight
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (column_backlog != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_view(input logic [15:0] px, input logic [15:0] py,
                           input logic [15:0] ang, input logic [15:0] fov);
      write_reg(gdrc_pkg::CSR_PLAYER_X, px);
      write_reg(gdrc_pkg::CSR_PLAYER_Y, py);
      write_reg(gdrc_pkg::CSR_PLAYER_ANGLE, ang);
      write_reg(gdrc_pkg::CSR_VIEW_SPAN, fov);
   endtask

   // a room: solid border rows and columns with scattered pillars
   task automatic build_room();
      logic [15:0] bits;
      for (int r = 0; r < 16; r++) begin
         if (r == 0 || r == 15) bits = 16'hFFFF;
         else bits = 16'h8001 | 16'($urandom & $urandom & $urandom & 32'h7FFE);
         store_row(r[3:0], bits);
      end
   endtask

   function automatic logic [15:0] random_row();
      case ($urandom_range(4))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         default: return 16'($urandom & $urandom & $urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] phase_view [8][4];
      calm          = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_command   = gdrc_pkg::CMD_MAP_WRITE;
      req_column    = '0;
      req_row_index = '0;
      req_row_walls = '0;
      csr_write     = 1'b0;
      csr_index     = gdrc_pkg::CSR_PLAYER_X;
      csr_data      = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty map at reset view, screen edges and columns past the screen
      cast(10'd0);
      cast(10'd639);
      cast(10'd1023);
      cast(10'd320);
      // row index extremes, all-wall and empty rows
      store_row(4'd0, 16'hFFFF);
      store_row(4'd15, 16'hFFFF);
      store_row(4'd7, 16'h8001);
      store_row(4'd1, 16'h0000);
      cast(10'd320);
      cast(10'd512);
      drain();
      // player at the origin corner, which lies in a wall cell, looking along both axes
      set_view(16'd0, 16'd0, 16'd0, 16'd0);
      cast(10'd0);
      cast(10'd1023);
      drain();
      write_reg(gdrc_pkg::CSR_PLAYER_ANGLE, 16'd16384);
      cast(10'd100);
      drain();
      // far corner, widest field, player standing inside a wall cell
      set_view(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      cast(10'd0);
      cast(10'd639);
      cast(10'd1023);
      store_row(4'd15, 16'h0000);
      cast(10'd333);
      drain();

      phase_view[0] = '{16'd6144, 16'd6144, 16'd0, 16'd10923};
      phase_view[1] = '{16'd32768, 16'd32768, 16'd0, 16'd1};
      phase_view[2] = '{16'd8191, 16'd61440, 16'd49152, 16'd32767};
      phase_view[3] = '{16'd4096, 16'd4096, 16'd8192, 16'd0};
      phase_view[4] = '{16'd0, 16'd65535, 16'd32768, 16'd20000};
      phase_view[5] = '{16'd40000, 16'd20000, 16'd12345, 16'd10923};
      phase_view[6] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      phase_view[7] = '{16'd65535, 16'd0, 16'd65535, 16'd5461};

      // random phases, each under its own view settings
      for (int p = 0; p < 8; p++) begin
         calm = (p == 5);
         set_view(phase_view[p][0], phase_view[p][1], phase_view[p][2], phase_view[p][3]);
         if (p != 3) build_room();
         for (int n = 0; n < 150; n++) begin
            if ($urandom_range(99) < 15) store_row(4'($urandom), random_row());
            else if ($urandom_range(9) == 0) cast(10'($urandom_range(1023, 640)));
            else cast(10'($urandom_range(639)));
            // hold off until the block has delivered everything
            if (n == 75 && p[0]) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (column_backlog != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (fail_count == 0 && column_backlog == 0) begin
         $display("tb_grid_dda_raycast_column OK");
      end else begin
         $display("tb_grid_dda_raycast_column NOT OK");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/gdrc_pkg.sv
hw/rtl/gdrc_front.sv
hw/rtl/gdrc_queue.sv
hw/rtl/gdrc_div.sv
hw/rtl/gdrc_march.sv
hw/rtl/grid_dda_raycast_column.sv
test/grid_dda_raycast_column_checker.sv
test/tb_grid_dda_raycast_column.sv
